@@ rtl/bbps_pkg.sv @@
// Shared types, codes and microcode table for the byte buffer with pattern search.
package bbps_pkg;

   // Default sizes
   localparam int BUFFER_DEPTH_DEF = 64;
   localparam int PATTERN_MAX_DEF  = 8;

   // Field widths of the request and result channels
   localparam int MODE_W = 3;
   localparam int BYTE_W = 8;
   localparam int SKIP_W = 7;
   localparam int PAT_W  = 64;
   localparam int PLEN_W = 4;
   localparam int MPOS_W = 6;
   localparam int WPOS_W = 7;

   // Command modes
   localparam logic [MODE_W-1:0] MODE_STORE     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REWIND    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SKIP      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND_PAT  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_FIND_BYTE = 3'd5;

   // Datapath operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
   localparam logic [OP_W-1:0] OP_LATCH  = 3'd1;
   localparam logic [OP_W-1:0] OP_STORE  = 3'd2;
   localparam logic [OP_W-1:0] OP_REWIND = 3'd3;
   localparam logic [OP_W-1:0] OP_SKIP   = 3'd4;
   localparam logic [OP_W-1:0] OP_ZERO   = 3'd5;
   localparam logic [OP_W-1:0] OP_READ   = 3'd6;
   localparam logic [OP_W-1:0] OP_EMIT   = 3'd7;

   // Jump conditions
   localparam int JC_W = 3;
   localparam logic [JC_W-1:0] JC_NEXT     = 3'd0;
   localparam logic [JC_W-1:0] JC_GOTO     = 3'd1;
   localparam logic [JC_W-1:0] JC_LOOP     = 3'd2;
   localparam logic [JC_W-1:0] JC_WAIT_REQ = 3'd3;
   localparam logic [JC_W-1:0] JC_WAIT_OUT = 3'd4;

   // Microprogram step addresses
   localparam int UPC_W = 4;
   localparam logic [UPC_W-1:0] S_INIT   = 4'd0;
   localparam logic [UPC_W-1:0] S_IDLE   = 4'd1;
   localparam logic [UPC_W-1:0] S_STORE  = 4'd2;
   localparam logic [UPC_W-1:0] S_REWIND = 4'd3;
   localparam logic [UPC_W-1:0] S_SKIP   = 4'd4;
   localparam logic [UPC_W-1:0] S_CLEAR  = 4'd5;
   localparam logic [UPC_W-1:0] S_EMIT   = 4'd6;
   localparam logic [UPC_W-1:0] S_FIND   = 4'd7;
   localparam logic [UPC_W-1:0] S_DRAIN  = 4'd8;
   localparam logic [UPC_W-1:0] S_DRAIN2 = 4'd9;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [JC_W-1:0]  jc;
      logic [UPC_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic              accept;
      logic [MODE_W-1:0] mode;
      logic              last;
      logic              out_free;
   } seq_status_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [BYTE_W-1:0] data_byte;
      logic [SKIP_W-1:0] skip_count;
      logic [PAT_W-1:0]  pattern;
      logic [PLEN_W-1:0] pattern_length;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [MPOS_W-1:0] match_position;
      logic [WPOS_W-1:0] write_position;
      logic              dropped;
   } rsp_type;

   // Build one control word
   function automatic ctrl_type cw(logic [OP_W-1:0] op, logic [JC_W-1:0] jc,
                                   logic [UPC_W-1:0] target);
      ctrl_type w;
      w.op     = op;
      w.jc     = jc;
      w.target = target;
      return w;
   endfunction

   // Control store: one word per step
   function automatic ctrl_type ucode_rom(logic [UPC_W-1:0] upc);
      ctrl_type w;
      unique case (upc)
         S_INIT:   w = cw(OP_ZERO,   JC_LOOP,     S_INIT);
         S_IDLE:   w = cw(OP_LATCH,  JC_WAIT_REQ, S_IDLE);
         S_STORE:  w = cw(OP_STORE,  JC_GOTO,     S_EMIT);
         S_REWIND: w = cw(OP_REWIND, JC_GOTO,     S_EMIT);
         S_SKIP:   w = cw(OP_SKIP,   JC_GOTO,     S_EMIT);
         S_CLEAR:  w = cw(OP_ZERO,   JC_LOOP,     S_CLEAR);
         S_EMIT:   w = cw(OP_EMIT,   JC_WAIT_OUT, S_IDLE);
         S_FIND:   w = cw(OP_READ,   JC_LOOP,     S_FIND);
         S_DRAIN:  w = cw(OP_NOP,    JC_NEXT,     S_DRAIN);
         S_DRAIN2: w = cw(OP_NOP,    JC_GOTO,     S_EMIT);
         default:  w = cw(OP_NOP,    JC_GOTO,     S_IDLE);
      endcase
      return w;
   endfunction

   // Entry step for each command mode
   function automatic logic [UPC_W-1:0] dispatch(logic [MODE_W-1:0] mode);
      logic [UPC_W-1:0] s;
      unique case (mode)
         MODE_STORE:     s = S_STORE;
         MODE_REWIND:    s = S_REWIND;
         MODE_SKIP:      s = S_SKIP;
         MODE_CLEAR:     s = S_CLEAR;
         MODE_FIND_PAT:  s = S_FIND;
         MODE_FIND_BYTE: s = S_FIND;
         default:        s = S_EMIT;
      endcase
      return s;
   endfunction

endpackage

@@ rtl/bbps_if.sv @@
// Request and result channel interfaces with valid/ready handshake.
interface bbps_req_if;
   logic                          valid;
   logic                          ready;
   logic [bbps_pkg::MODE_W-1:0]   mode;
   logic [bbps_pkg::BYTE_W-1:0]   data_byte;
   logic [bbps_pkg::SKIP_W-1:0]   skip_count;
   logic [bbps_pkg::PAT_W-1:0]    pattern;
   logic [bbps_pkg::PLEN_W-1:0]   pattern_length;

   modport source (output valid, mode, data_byte, skip_count, pattern, pattern_length,
                   input ready);
   modport sink   (input valid, mode, data_byte, skip_count, pattern, pattern_length,
                   output ready);
endinterface

interface bbps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [bbps_pkg::MPOS_W-1:0]   match_position;
   logic [bbps_pkg::WPOS_W-1:0]   write_position;
   logic                          dropped;

   modport source (output valid, found, match_position, write_position, dropped,
                   input ready);
   modport sink   (input valid, found, match_position, write_position, dropped,
                   output ready);
endinterface

@@ rtl/byte_buffer_with_pattern_search.sv @@
// Top level: request/result handshake, result register, sequencer and datapath.
// Steps: store, rewind and skip pass from the idle step through their own step to emit;
// clear sweeps every buffer address first; find pattern and find byte scan the whole
// buffer, one byte per cycle through the single memory read port, then drain to emit.
// Throughput: one request at a time; the next is taken the cycle after its result is loaded.
// Reset: synchronous; a sweep over every buffer address zeroes the buffer before the
// first request is taken.
module byte_buffer_with_pattern_search #(
   parameter int BUFFER_DEPTH = bbps_pkg::BUFFER_DEPTH_DEF,
   parameter int PATTERN_MAX  = bbps_pkg::PATTERN_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bbps_req_if.sink    req_ch,
   bbps_rsp_if.source  rsp_ch
);

   bbps_pkg::ctrl_type       ctrl;
   bbps_pkg::seq_status_type status;
   bbps_pkg::req_type        req;
   bbps_pkg::rsp_type        result;
   bbps_pkg::rsp_type        rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     accept;
   logic                     last;
   logic                     out_free;
   logic                     emit;

   // Take a request only in the idle step
   assign req_ch.ready = (ctrl.op == bbps_pkg::OP_LATCH);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign emit         = (ctrl.op == bbps_pkg::OP_EMIT) && out_free;

   // Gather the request fields
   assign req.mode           = req_ch.mode;
   assign req.data_byte      = req_ch.data_byte;
   assign req.skip_count     = req_ch.skip_count;
   assign req.pattern        = req_ch.pattern;
   assign req.pattern_length = req_ch.pattern_length;

   assign status.accept   = accept;
   assign status.mode     = req_ch.mode;
   assign status.last     = last;
   assign status.out_free = out_free;

   bbps_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   bbps_datapath #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .PATTERN_MAX  (PATTERN_MAX)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .accept (accept),
      .req    (req),
      .last   (last),
      .result (result)
   );

   // Load the result register on emit, drop valid once taken
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (emit) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.found          = rsp_ff.found;
   assign rsp_ch.match_position = rsp_ff.match_position;
   assign rsp_ch.write_position = rsp_ff.write_position;
   assign rsp_ch.dropped        = rsp_ff.dropped;

`ifndef SYNTHESIS
   // A taken request leaves the idle step at once
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("request taken twice in a row");

   // A result appears only from the emit step
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.op == bbps_pkg::OP_EMIT))
      else $error("result valid without emit step");

   // A dropped store reports a full buffer
   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.dropped
         |-> rsp_ch.write_position == bbps_pkg::WPOS_W'(BUFFER_DEPTH))
      else $error("store dropped with room left");

   // No match reports position zero
   a_no_match_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.found |-> rsp_ch.match_position == '0)
      else $error("position set without a match");
`endif

endmodule

@@ rtl/bbps_useq.sv @@
// Microprogram sequencer: step counter, control store and conditional jumps.
module bbps_useq (
   input  logic                     clock,
   input  logic                     reset,
   input  bbps_pkg::seq_status_type status,
   output bbps_pkg::ctrl_type       ctrl
);

   logic [bbps_pkg::UPC_W-1:0] upc_ff;
   logic [bbps_pkg::UPC_W-1:0] upc_in;

   // Fetch the control word of the current step
   assign ctrl = bbps_pkg::ucode_rom(upc_ff);

   // Pick the next step
   always_comb begin
      unique case (ctrl.jc)
         bbps_pkg::JC_NEXT:     upc_in = upc_ff + 1'b1;
         bbps_pkg::JC_GOTO:     upc_in = ctrl.target;
         bbps_pkg::JC_LOOP:     upc_in = status.last ? upc_ff + 1'b1 : ctrl.target;
         bbps_pkg::JC_WAIT_REQ: upc_in = status.accept ? bbps_pkg::dispatch(status.mode)
                                                       : upc_ff;
         bbps_pkg::JC_WAIT_OUT: upc_in = status.out_free ? ctrl.target : upc_ff;
         default:               upc_in = bbps_pkg::S_IDLE;
      endcase
   end

   // Start with the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= bbps_pkg::S_INIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

@@ rtl/bbps_datapath.sv @@
// Buffer memory, write index, scan window and result registers.
module bbps_datapath #(
   parameter int BUFFER_DEPTH = bbps_pkg::BUFFER_DEPTH_DEF,
   parameter int PATTERN_MAX  = bbps_pkg::PATTERN_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  bbps_pkg::ctrl_type ctrl,
   input  logic               accept,
   input  bbps_pkg::req_type  req,
   output logic               last,
   output bbps_pkg::rsp_type  result
);

   localparam int AW    = $clog2(BUFFER_DEPTH);
   localparam int IW    = $clog2(BUFFER_DEPTH + 1);
   localparam int LW    = $clog2(PATTERN_MAX + 1);
   localparam int SUMW  = ((IW > bbps_pkg::SKIP_W) ? IW : bbps_pkg::SKIP_W) + 1;
   localparam int MPW   = bbps_pkg::MPOS_W;
   localparam int WPW   = bbps_pkg::WPOS_W;
   localparam int BW    = bbps_pkg::BYTE_W;

   logic [BW-1:0]  mem [BUFFER_DEPTH];
   logic [BW-1:0]  rdata_ff;

   logic [IW-1:0]  widx_ff, widx_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic [BW-1:0]  byte_ff, byte_in;
   logic [bbps_pkg::SKIP_W-1:0] skip_ff, skip_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [BW-1:0]  rpat_ff [PATTERN_MAX];
   logic [BW-1:0]  rpat_in [PATTERN_MAX];
   logic [BW-1:0]  win_ff  [PATTERN_MAX];
   logic [BW-1:0]  win_in  [PATTERN_MAX];
   logic           rvld_ff, rvld_in;
   logic [AW-1:0]  raddr_ff, raddr_in;
   logic           wvld_ff, wvld_in;
   logic [AW-1:0]  wpos_ff, wpos_in;
   logic           found_ff, found_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic           dropped_ff, dropped_in;

   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [BW-1:0]  mem_wdata;
   logic           has_room;
   logic [SUMW-1:0] skip_sum;
   logic [LW-1:0]  len_req;
   logic [PATTERN_MAX-1:0] slot_ok;
   logic           hit;

   assign last     = (addr_ff == AW'(BUFFER_DEPTH - 1));
   assign has_room = (widx_ff < IW'(BUFFER_DEPTH));
   assign skip_sum = SUMW'(widx_ff) + SUMW'(skip_ff);

   // Clamp the requested pattern length; a byte search is a one-byte pattern
   always_comb begin
      if (req.mode == bbps_pkg::MODE_FIND_BYTE || req.pattern_length == '0) begin
         len_req = LW'(1);
      end else if (int'(req.pattern_length) > PATTERN_MAX) begin
         len_req = LW'(PATTERN_MAX);
      end else begin
         len_req = LW'(req.pattern_length);
      end
   end

   // Align the pattern to the window: slot s holds pattern byte len-1-s
   always_comb begin
      for (int s = 0; s < PATTERN_MAX; s++) begin
         rpat_in[s] = '0;
         for (int k = 0; k < PATTERN_MAX; k++) begin
            if (s + k + 1 == int'(len_req)) begin
               rpat_in[s] = (req.mode == bbps_pkg::MODE_FIND_BYTE) ? req.data_byte
                                                                  : req.pattern[8*k +: 8];
            end
         end
      end
   end

   // Compare the window against the aligned pattern
   always_comb begin
      for (int s = 0; s < PATTERN_MAX; s++) begin
         slot_ok[s] = (s >= int'(len_ff)) || (win_ff[s] == rpat_ff[s]);
      end
      hit = wvld_ff && (int'(wpos_ff) + 1 >= int'(len_ff)) && (&slot_ok);
   end

   // Memory write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      if (ctrl.op == bbps_pkg::OP_STORE && has_room) begin
         mem_we    = 1'b1;
         mem_waddr = widx_ff[AW-1:0];
         mem_wdata = byte_ff;
      end else if (ctrl.op == bbps_pkg::OP_ZERO) begin
         mem_we = 1'b1;
      end
   end

   // Next values of the datapath registers
   always_comb begin
      widx_in    = widx_ff;
      addr_in    = addr_ff;
      byte_in    = byte_ff;
      skip_in    = skip_ff;
      len_in     = len_ff;
      found_in   = found_ff;
      pos_in     = pos_ff;
      dropped_in = dropped_ff;
      rvld_in    = (ctrl.op == bbps_pkg::OP_READ);
      raddr_in   = addr_ff;
      wvld_in    = rvld_ff;
      wpos_in    = raddr_ff;
      for (int s = 0; s < PATTERN_MAX; s++) begin
         win_in[s] = win_ff[s];
      end

      unique case (ctrl.op)
         bbps_pkg::OP_LATCH: begin
            if (accept) begin
               byte_in    = req.data_byte;
               skip_in    = req.skip_count;
               len_in     = len_req;
               found_in   = 1'b0;
               pos_in     = '0;
               dropped_in = 1'b0;
            end
         end
         bbps_pkg::OP_STORE: begin
            if (has_room) begin
               widx_in = widx_ff + 1'b1;
            end else begin
               dropped_in = 1'b1;
            end
         end
         bbps_pkg::OP_REWIND: widx_in = '0;
         bbps_pkg::OP_SKIP: begin
            if (skip_sum < SUMW'(BUFFER_DEPTH - 1)) begin
               widx_in = IW'(skip_sum);
            end else begin
               widx_in = IW'(BUFFER_DEPTH - 1);
            end
         end
         bbps_pkg::OP_ZERO: begin
            widx_in = '0;
            addr_in = last ? '0 : addr_ff + 1'b1;
         end
         bbps_pkg::OP_READ: addr_in = last ? '0 : addr_ff + 1'b1;
         default: ;
      endcase

      // Shift the newest byte into the window
      if (rvld_ff) begin
         for (int s = 0; s < PATTERN_MAX; s++) begin
            win_in[s] = (s == 0) ? rdata_ff : win_ff[(s == 0) ? 0 : s - 1];
         end
      end

      // Keep the lowest matching position
      if (hit && !found_ff) begin
         found_in = 1'b1;
         pos_in   = wpos_ff - AW'(len_ff - LW'(1));
      end
   end

   // Buffer memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff <= '0;
         addr_ff <= '0;
         rvld_ff <= 1'b0;
         wvld_ff <= 1'b0;
      end else begin
         widx_ff <= widx_in;
         addr_ff <= addr_in;
         rvld_ff <= rvld_in;
         wvld_ff <= wvld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      skip_ff    <= skip_in;
      len_ff     <= len_in;
      raddr_ff   <= raddr_in;
      wpos_ff    <= wpos_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      dropped_ff <= dropped_in;
      for (int s = 0; s < PATTERN_MAX; s++) begin
         win_ff[s] <= win_in[s];
         if (ctrl.op == bbps_pkg::OP_LATCH && accept) begin
            rpat_ff[s] <= rpat_in[s];
         end
      end
   end

   // Format the result fields
   assign result.found          = found_ff;
   assign result.match_position = MPW'(pos_ff);
   assign result.write_position = WPW'(widx_ff);
   assign result.dropped        = dropped_ff;

endmodule
